### sv/acfb_pkg.sv
// Shared types, constants and functions for the AES CFB128 mode engine.
// No dependencies.
package acfb_pkg;
   localparam int MaxRounds = 14;

   localparam logic [2:0] CSR_KEY0 = 3'd0;
   localparam logic [2:0] CSR_KEY1 = 3'd1;
   localparam logic [2:0] CSR_KEY2 = 3'd2;
   localparam logic [2:0] CSR_KEY3 = 3'd3;
   localparam logic [2:0] CSR_ROUNDS = 3'd4;
   localparam logic [2:0] CSR_DIR = 3'd5;
   localparam logic [2:0] CSR_IV_HI = 3'd6;
   localparam logic [2:0] CSR_IV_LO = 3'd7;

   typedef struct packed {
      logic [127:0] data;
      logic         first;
   } req_item_type;

   function automatic logic [7:0] sbox(input logic [7:0] a);
      logic [7:0] t [256];
      t = '{
 8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
 8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
 8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
 8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
 8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
 8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
 8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
 8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
 8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
 8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
 8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
 8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
 8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
 8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
 8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
 8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
      return t[a];
   endfunction

   function automatic logic [7:0] xtime(input logic [7:0] b);
      return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
   endfunction

   function automatic logic [31:0] sub_word(input logic [31:0] w);
      return {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
   endfunction

   // One AES round: byte 0 of the state sits in bits 127:120.
   function automatic logic [127:0] aes_round(input logic [127:0] s, input logic last,
                                              input logic [127:0] rk);
      logic [7:0] t [16];
      logic [7:0] u [16];
      logic [7:0] a0, a1, a2, a3, al;
      logic [127:0] o;
      for (int i = 0; i < 16; i++) t[i] = sbox(s[127 - 8*i -: 8]);
      for (int c = 0; c < 4; c++)
         for (int i = 0; i < 4; i++) u[i + 4*c] = t[i + 4*((c + i) % 4)];
      for (int c = 0; c < 4; c++) begin
         a0 = u[4*c]; a1 = u[4*c+1]; a2 = u[4*c+2]; a3 = u[4*c+3];
         al = a0 ^ a1 ^ a2 ^ a3;
         if (!last) begin
            u[4*c]   = a0 ^ al ^ xtime(a0 ^ a1);
            u[4*c+1] = a1 ^ al ^ xtime(a1 ^ a2);
            u[4*c+2] = a2 ^ al ^ xtime(a2 ^ a3);
            u[4*c+3] = a3 ^ al ^ xtime(a3 ^ a0);
         end
      end
      for (int i = 0; i < 16; i++) o[127 - 8*i -: 8] = u[i];
      return o ^ rk;
   endfunction
endpackage

### sv/acfb_key_expand.sv
// Sequential AES key expansion: one 32-bit word per cycle into the round key store.
// Depends on acfb_pkg.
module acfb_key_expand (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic [255:0] key,
   input  logic [1:0]   round_select,
   input  logic [3:0]   rd_round,
   output logic [127:0] rd_key,
   output logic         busy,
   output logic [3:0]   num_rounds
);
   logic [31:0]  win_ff [8];
   logic [31:0]  win_in [8];
   logic [5:0]   idx_ff, idx_in;
   logic [3:0]   nk_ff, nk_in;
   logic [3:0]   pos_ff, pos_in;
   logic [7:0]   rcon_ff, rcon_in;
   logic         busy_ff, busy_in;
   logic [3:0]   nr_ff, nr_in;
   logic [127:0] mem [acfb_pkg::MaxRounds + 1];
   logic [31:0]  t, nw, wd;
   logic [2:0]   tail;
   logic [5:0]   total;
   logic [1:0]   sel;

   always_comb begin
      sel = (round_select == 2'd3) ? 2'd2 : round_select;
      total = 6'(4 * (int'(nr_ff) + 1));
      tail = 3'(nk_ff - 4'd1);
      t = win_ff[tail];
      if (pos_ff == 4'd0) t = acfb_pkg::sub_word({t[23:0], t[31:24]}) ^ {rcon_ff, 24'd0};
      else if (nk_ff > 4'd6 && pos_ff == 4'd4) t = acfb_pkg::sub_word(t);
      nw = win_ff[0] ^ t;
      wd = (idx_ff < 6'(nk_ff)) ? win_ff[idx_ff[2:0]] : nw;
      win_in = win_ff; idx_in = idx_ff; nk_in = nk_ff; pos_in = pos_ff;
      rcon_in = rcon_ff; busy_in = busy_ff; nr_in = nr_ff;
      if (start) begin
         nk_in = 4'(4 + 2 * int'(sel));
         nr_in = 4'(10 + 2 * int'(sel));
         for (int i = 0; i < 8; i++) win_in[i] = key[255 - 32*i -: 32];
         idx_in = 6'd0; pos_in = 4'd0; rcon_in = 8'h01; busy_in = 1'b1;
      end else if (busy_ff) begin
         // while idx is below nk the key words are copied out of the window unchanged;
         // afterwards the window holds the last nk words
         if (idx_ff >= 6'(nk_ff)) begin
            for (int i = 0; i < 7; i++) win_in[i] = win_ff[i+1];
            win_in[tail] = nw;
            pos_in = (pos_ff == nk_ff - 4'd1) ? 4'd0 : pos_ff + 4'd1;
            if (pos_ff == 4'd0) rcon_in = acfb_pkg::xtime(rcon_ff);
         end
         idx_in = idx_ff + 6'd1;
         if (idx_ff == total - 6'd1) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0; idx_ff <= '0; nk_ff <= 4'd4; pos_ff <= '0; rcon_ff <= 8'h01;
         nr_ff <= 4'd10;
      end else begin
         busy_ff <= busy_in; idx_ff <= idx_in; nk_ff <= nk_in; pos_ff <= pos_in;
         rcon_ff <= rcon_in; nr_ff <= nr_in;
      end
      win_ff <= win_in;
   end

   always_ff @(posedge clock) begin
      if (busy_ff) mem[idx_ff[5:2]][127 - 32 * int'(idx_ff[1:0]) -: 32] <= wd;
   end

   assign rd_key = mem[rd_round];
   assign busy = busy_ff;
   assign num_rounds = nr_ff;
endmodule

### sv/aes_cfb128_mode_engine_unit.sv
// Top level of the AES CFB128 mode engine: request queue, round engine, result register.
// Depends on acfb_pkg and acfb_key_expand.
// Each block runs Nr = 10, 12 or 14 rounds. One block is in the round engine at a time:
//   the single shared round unit and the feedback from each result into the next block
//   mean a new request starts only after the previous block has left the round engine.
// Reset (synchronous, active high) clears the control and configuration registers and
//   runs key expansion of the zero key; requests wait until it is done.
module aes_cfb128_mode_engine_unit (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [127:0] req_tdata,  // data_high[63:0], data_low[127:64]
   input  logic         req_tuser,  // first_block
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [127:0] rsp_tdata,  // result_high[63:0], result_low[127:64]
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [2:0]   csr_index,
   input  logic [63:0]  csr_data
);
   logic [63:0]  key_ff [4];
   logic [1:0]   rsel_ff;
   logic         dir_ff;
   logic [127:0] iv_ff, fb_ff, st_ff, dat_ff, res_ff;
   logic         kick_ff;
   // front queue of two requests
   acfb_pkg::req_item_type q_ff [2];
   logic [1:0]   qcnt_ff;
   logic         qrd_ff, qwr_ff;
   logic         run_ff, rv_ff;
   logic [3:0]   rnd_ff;
   logic         kbusy;
   logic [3:0]   nr;
   logic [127:0] rk, blk, enc;
   logic         q_push, q_pop, fin, done, kick_in;
   acfb_pkg::req_item_type head;

   acfb_key_expand u_kx (
      .clock(clock), .reset(reset), .start(kick_ff),
      .key({key_ff[0], key_ff[1], key_ff[2], key_ff[3]}),
      .round_select(rsel_ff), .rd_round(rnd_ff), .rd_key(rk),
      .busy(kbusy), .num_rounds(nr));

   assign csr_ready = 1'b1;
   // a key word or round count write restarts key expansion
   assign kick_in = csr_valid && csr_ready && csr_index <= acfb_pkg::CSR_ROUNDS;
   assign req_tready = qcnt_ff != 2'd2;
   assign q_push = req_tvalid && req_tready;
   assign head = q_ff[qrd_ff];
   // start a block when idle and keys ready
   assign q_pop = !run_ff && !kbusy && !kick_ff && qcnt_ff != 2'd0;
   // hold the last round while an older result still waits in the result register
   assign fin = run_ff && rnd_ff == nr;
   assign done = fin && (!rv_ff || rsp_tready);
   assign enc = acfb_pkg::aes_round(st_ff, rnd_ff == nr, rk);
   assign blk = head.first ? iv_ff : fb_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 4; i++) key_ff[i] <= '0;
         rsel_ff <= '0; dir_ff <= 1'b0; iv_ff <= '0; fb_ff <= '0;
         kick_ff <= 1'b1; qcnt_ff <= '0; qrd_ff <= 1'b0; qwr_ff <= 1'b0;
         run_ff <= 1'b0; rv_ff <= 1'b0; rnd_ff <= '0;
      end else begin
         kick_ff <= kick_in;
         if (csr_valid) begin
            unique case (csr_index)
               acfb_pkg::CSR_KEY0: key_ff[0] <= csr_data;
               acfb_pkg::CSR_KEY1: key_ff[1] <= csr_data;
               acfb_pkg::CSR_KEY2: key_ff[2] <= csr_data;
               acfb_pkg::CSR_KEY3: key_ff[3] <= csr_data;
               acfb_pkg::CSR_ROUNDS: rsel_ff <= csr_data[1:0];
               acfb_pkg::CSR_DIR: dir_ff <= csr_data[0];
               acfb_pkg::CSR_IV_HI: iv_ff[127:64] <= csr_data;
               acfb_pkg::CSR_IV_LO: iv_ff[63:0] <= csr_data;
               default: ;
            endcase
         end
         if (q_push) qwr_ff <= !qwr_ff;
         if (q_pop) qrd_ff <= !qrd_ff;
         qcnt_ff <= qcnt_ff + {1'b0, q_push} - {1'b0, q_pop};
         if (q_pop) begin
            run_ff <= 1'b1; rnd_ff <= 4'd0;
         end else if (done) begin
            run_ff <= 1'b0;
            fb_ff <= dir_ff ? dat_ff : (enc ^ dat_ff);
         end else if (run_ff && !fin) begin
            rnd_ff <= rnd_ff + 4'd1;
         end
         // a new result may replace the one taken at the same edge
         rv_ff <= done || (rv_ff && !rsp_tready);
      end
   end

   always_ff @(posedge clock) begin
      if (q_push) q_ff[qwr_ff] <= '{data: req_tdata, first: req_tuser};
      if (q_pop) begin
         dat_ff <= {head.data[63:0], head.data[127:64]};
         st_ff <= blk;
      end else if (run_ff && !fin) begin
         // round 0 is the key whitening, rnd_ff then walks rounds 1..Nr
         st_ff <= (rnd_ff == 4'd0) ? (st_ff ^ rk) : enc;
      end
      if (done) res_ff <= enc ^ dat_ff;
   end

   // whitening cycle uses rk only; rounds use aes_round
   assign rsp_tvalid = rv_ff;
   assign rsp_tdata = {res_ff[63:0], res_ff[127:64]};

   a_qcnt: assert property (@(posedge clock) disable iff (reset) qcnt_ff != 2'd3)
      else $error("queue overflow");
   a_rv_hold: assert property (@(posedge clock) disable iff (reset)
      rv_ff && !rsp_tready |=> rv_ff && $stable(res_ff)) else $error("result lost");
   a_no_pop_busy: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !kbusy) else $error("start during key expansion");
endmodule

### dv/aes_cfb128_mode_engine_unit_tb.sv
// Self-checking testbench for the AES CFB128 mode engine: known-answer blocks,
// then random messages under several keys, round counts and directions.
// Depends on acfb_pkg and the aes_cfb128_mode_engine_unit RTL.
`timescale 1ns / 1ps

module aes_cfb128_mode_engine_unit_tb;
   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [127:0] req_tdata;
   logic         req_tuser;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [127:0] rsp_tdata;
   logic         csr_valid;
   logic         csr_ready;
   logic [2:0]   csr_index;
   logic [63:0]  csr_data;

   aes_cfb128_mode_engine_unit u_dut (.*);

   // One output block as the engine reports it.
   typedef struct packed {
      logic [63:0] hi;
      logic [63:0] lo;
   } block_type;

   // Row of the directed stimulus table. When reprog is set, drain the engine
   // and load the counting key, the standard IV, rsel and dir before the row.
   typedef struct packed {
      logic        reprog;
      logic [1:0]  rsel;
      logic        dir;
      logic        first;
      logic [63:0] hi;
      logic [63:0] lo;
      logic        known;
      logic [63:0] exp_hi;
      logic [63:0] exp_lo;
   } vec_type;

   localparam logic [63:0] ONES = 64'hffff_ffff_ffff_ffff;
   localparam logic [63:0] KZ_HI = 64'h66e94bd4ef8a2c3b;  // AES-128 of zeros, zero key
   localparam logic [63:0] KZ_LO = 64'h884cfa59ca342b2e;
   localparam logic [63:0] K128_HI = 64'h69c4e0d86a7b0430;  // standard known answers
   localparam logic [63:0] K128_LO = 64'hd8cdb78070b4c55a;
   localparam logic [63:0] K192_HI = 64'hdda97ca4864cdfe0;
   localparam logic [63:0] K192_LO = 64'h6eaf70a0ec0d7191;
   localparam logic [63:0] K256_HI = 64'h8ea2b7ca516745bf;
   localparam logic [63:0] K256_LO = 64'heafc49904b496089;

   // Model state: configuration, feedback and expanded key schedule.
   logic [63:0]  key_reg [4];
   logic [1:0]   rsel_reg;
   logic         dir_reg;
   logic [63:0]  iv_hi_reg, iv_lo_reg;
   logic [127:0] feedback;
   logic [127:0] sched [15];
   int           nrounds;
   logic [7:0]   sb [256];

   block_type    pending_blocks[$];
   int           errors = 0;
   int           snd_pct, rcv_pct;
   event         hold_ev;
   logic         hold_on;

   function automatic logic [7:0] dbl(input logic [7:0] b);
      return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
   endfunction

   function automatic logic [31:0] sub4(input logic [31:0] w);
      return {sb[w[31:24]], sb[w[23:16]], sb[w[15:8]], sb[w[7:0]]};
   endfunction

   // Rebuild the round keys; select three behaves like the 256-bit key.
   function automatic void expand_schedule();
      logic [31:0] w [60];
      logic [31:0] t;
      logic [7:0]  rc;
      int          sel, nk;
      sel = (rsel_reg > 2) ? 2 : rsel_reg;
      nk = 4 + 2 * sel;
      nrounds = 10 + 2 * sel;
      rc = 8'h01;
      for (int i = 0; i < nk; i++)
         w[i] = (i % 2) ? key_reg[i / 2][31:0] : key_reg[i / 2][63:32];
      for (int i = nk; i < 4 * (nrounds + 1); i++) begin
         t = w[i - 1];
         if (i % nk == 0) begin
            t = sub4({t[23:0], t[31:24]}) ^ {rc, 24'h0};
            rc = dbl(rc);
         end else if (nk > 6 && i % nk == 4) begin
            t = sub4(t);
         end
         w[i] = w[i - nk] ^ t;
      end
      for (int r = 0; r <= nrounds; r++)
         sched[r] = {w[4*r], w[4*r+1], w[4*r+2], w[4*r+3]};
   endfunction

   // Forward cipher; state byte 0 sits in bits 127:120.
   function automatic logic [127:0] cipher(input logic [127:0] pt);
      logic [7:0]   s [16];
      logic [7:0]   t [16];
      logic [7:0]   a0, a1, a2, a3, al;
      logic [127:0] x;
      x = pt ^ sched[0];
      for (int r = 1; r <= nrounds; r++) begin
         for (int i = 0; i < 16; i++) t[i] = sb[x[127 - 8*i -: 8]];
         for (int c = 0; c < 4; c++)
            for (int i = 0; i < 4; i++) s[i + 4*c] = t[i + 4*((c + i) % 4)];
         if (r != nrounds) begin
            for (int c = 0; c < 4; c++) begin
               a0 = s[4*c]; a1 = s[4*c+1]; a2 = s[4*c+2]; a3 = s[4*c+3];
               al = a0 ^ a1 ^ a2 ^ a3;
               s[4*c]   = a0 ^ al ^ dbl(a0 ^ a1);
               s[4*c+1] = a1 ^ al ^ dbl(a1 ^ a2);
               s[4*c+2] = a2 ^ al ^ dbl(a2 ^ a3);
               s[4*c+3] = a3 ^ al ^ dbl(a3 ^ a0);
            end
         end
         for (int i = 0; i < 16; i++) x[127 - 8*i -: 8] = s[i];
         x = x ^ sched[r];
      end
      return x;
   endfunction

   // Advance the feedback by one block and return the output block.
   function automatic block_type cfb_step(input logic first, input logic [63:0] hi,
                                          input logic [63:0] lo);
      block_type res;
      if (first) feedback = {iv_hi_reg, iv_lo_reg};
      {res.hi, res.lo} = {hi, lo} ^ cipher(feedback);
      feedback = dir_reg ? {hi, lo} : {res.hi, res.lo};
      return res;
   endfunction

   function automatic logic [63:0] rnd64();
      case ($urandom_range(7))
         0: return 64'h0;
         1: return ONES;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   // Clock.
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Hard stop in case the engine hangs.
   initial begin
      #6_000_000;
      $display("aes_cfb128_mode_engine_unit_tb NOT OK");
      $finish;
   end

   // Pressure stretch: count the hold-off cycles here.
   initial begin
      hold_on = 1'b0;
      forever begin
         @(hold_ev);
         hold_on <= 1'b1;
         repeat (400) @(posedge clock);
         hold_on <= 1'b0;
      end
   end

   // Result side: stall at the phase's rate, or hold off fully during a
   // pressure stretch so the engine backs up into the request port.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_on) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rcv_pct);
      end
   end

   // Compare each accepted result against the oldest pending block.
   always @(posedge clock) begin
      block_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_blocks.size() == 0) begin
            $error("unexpected result %h", rsp_tdata);
            errors++;
         end else begin
            want = pending_blocks.pop_front();
            if (rsp_tdata[63:0] !== want.hi) begin
               $error("result_high: expected %h, got %h", want.hi, rsp_tdata[63:0]);
               errors++;
            end
            if (rsp_tdata[127:64] !== want.lo) begin
               $error("result_low: expected %h, got %h", want.lo, rsp_tdata[127:64]);
               errors++;
            end
         end
      end
   end

   // Write one register; leave csr_valid high for a following write.
   task automatic csr_write(input logic [2:0] idx, input logic [63:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         acfb_pkg::CSR_KEY0, acfb_pkg::CSR_KEY1,
         acfb_pkg::CSR_KEY2, acfb_pkg::CSR_KEY3: key_reg[idx[1:0]] = val;
         acfb_pkg::CSR_ROUNDS: rsel_reg = val[1:0];
         acfb_pkg::CSR_DIR: dir_reg = val[0];
         acfb_pkg::CSR_IV_HI: iv_hi_reg = val;
         acfb_pkg::CSR_IV_LO: iv_lo_reg = val;
         default: ;
      endcase
      if (idx <= acfb_pkg::CSR_ROUNDS) expand_schedule();
   endtask

   task automatic program_all(input logic [63:0] k0, input logic [63:0] k1,
                              input logic [63:0] k2, input logic [63:0] k3,
                              input logic [1:0] rs, input logic dr,
                              input logic [63:0] ivh, input logic [63:0] ivl);
      csr_write(acfb_pkg::CSR_KEY0, k0);
      csr_write(acfb_pkg::CSR_KEY1, k1);
      csr_write(acfb_pkg::CSR_KEY2, k2);
      csr_write(acfb_pkg::CSR_KEY3, k3);
      csr_write(acfb_pkg::CSR_ROUNDS, {62'h0, rs});
      csr_write(acfb_pkg::CSR_DIR, {63'h0, dr});
      csr_write(acfb_pkg::CSR_IV_HI, ivh);
      csr_write(acfb_pkg::CSR_IV_LO, ivl);
      csr_valid <= 1'b0;
   endtask

   // Wait until every block has come back, then past the engine's latency.
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_blocks.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   // Offer one request; valid stays high afterwards unless the next call idles.
   task automatic send_block(input logic first, input logic [63:0] hi,
                             input logic [63:0] lo, input logic known,
                             input block_type given);
      block_type res;
      while ($urandom_range(99) < snd_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {lo, hi};
      req_tuser <= first;
      do @(posedge clock); while (!req_tready);
      res = cfb_step(first, hi, lo);
      pending_blocks.push_back(known ? given : res);
   endtask

   vec_type dir_vecs [13];

   initial begin
      sb = '{
 8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
 8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
 8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
 8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
 8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
 8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
 8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
 8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
 8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
 8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
 8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
 8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
 8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
 8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
 8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
 8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};

      // Rows before the first reprog run on the reset state: zero key, zero IV.
      dir_vecs = '{
         // no first block after reset: feedback starts from zero
         '{1'b0, 2'd0, 1'b0, 1'b0, 64'h0, 64'h0, 1'b1, KZ_HI, KZ_LO},
         '{1'b0, 2'd0, 1'b0, 1'b0, ONES, ONES, 1'b0, 64'h0, 64'h0},
         '{1'b0, 2'd0, 1'b0, 1'b1, 64'h0, 64'h0, 1'b1, KZ_HI, KZ_LO},
         '{1'b0, 2'd0, 1'b0, 1'b1, ONES, 64'h0, 1'b0, 64'h0, 64'h0},
         // counting key, standard IV, zero data: output is the raw cipher block
         '{1'b1, 2'd0, 1'b0, 1'b1, 64'h0, 64'h0, 1'b1, K128_HI, K128_LO},
         '{1'b0, 2'd0, 1'b0, 1'b0, 64'h0123456789abcdef, ONES, 1'b0, 64'h0, 64'h0},
         '{1'b1, 2'd1, 1'b0, 1'b1, 64'h0, 64'h0, 1'b1, K192_HI, K192_LO},
         '{1'b1, 2'd2, 1'b0, 1'b1, 64'h0, 64'h0, 1'b1, K256_HI, K256_LO},
         // round select three saturates to the 256-bit key
         '{1'b1, 2'd3, 1'b0, 1'b1, 64'h0, 64'h0, 1'b1, K256_HI, K256_LO},
         '{1'b0, 2'd3, 1'b0, 1'b0, ONES, ONES, 1'b0, 64'h0, 64'h0},
         // decrypt: ciphertext goes into the feedback
         '{1'b1, 2'd0, 1'b1, 1'b1, 64'h0, 64'h0, 1'b1, K128_HI, K128_LO},
         '{1'b0, 2'd0, 1'b1, 1'b0, ONES, 64'h5555aaaa5555aaaa, 1'b0, 64'h0, 64'h0},
         '{1'b0, 2'd0, 1'b1, 1'b1, 64'h8000000000000001, ONES, 1'b0, 64'h0, 64'h0}
      };

      snd_pct = 0;
      rcv_pct = 0;
      for (int i = 0; i < 4; i++) key_reg[i] = 64'h0;
      rsel_reg = 2'd0;
      dir_reg = 1'b0;
      iv_hi_reg = 64'h0;
      iv_lo_reg = 64'h0;
      feedback = 128'h0;
      expand_schedule();

      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = 1'b0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed table.
      foreach (dir_vecs[i]) begin
         if (dir_vecs[i].reprog) begin
            drain();
            program_all(64'h0001020304050607, 64'h08090a0b0c0d0e0f,
                        64'h1011121314151617, 64'h18191a1b1c1d1e1f,
                        dir_vecs[i].rsel, dir_vecs[i].dir,
                        64'h0011223344556677, 64'h8899aabbccddeeff);
         end
         send_block(dir_vecs[i].first, dir_vecs[i].hi, dir_vecs[i].lo,
                    dir_vecs[i].known, {dir_vecs[i].exp_hi, dir_vecs[i].exp_lo});
      end
      drain();

      // Random phases: each picks a fresh configuration and an idling mode;
      // most traffic is proper messages that open with a first block.
      for (int ph = 0; ph < 12; ph++) begin
         int cnt;
         int len;
         case (ph % 4)
            0: begin snd_pct = 0;  rcv_pct = 0;  end
            1: begin snd_pct = 61; rcv_pct = 0;  end
            2: begin snd_pct = 0;  rcv_pct = 61; end
            default: begin snd_pct = 25; rcv_pct = 25; end
         endcase
         if (ph == 1) program_all(ONES, ONES, ONES, ONES, 2'd2, 1'b1, ONES, ONES);
         else if (ph == 2) program_all(64'h0, 64'h0, 64'h0, 64'h0, 2'd0, 1'b0, 64'h0, 64'h0);
         else program_all(rnd64(), rnd64(), rnd64(), rnd64(), 2'($urandom_range(3)),
                          1'($urandom_range(1)), rnd64(), rnd64());
         // Hold the result port long enough for the engine to back up.
         if (ph == 4) -> hold_ev;
         cnt = 0;
         while (cnt < 62) begin
            len = $urandom_range(1, 8);
            for (int j = 0; j < len; j++) begin
               logic first;
               first = (j == 0) ? ($urandom_range(9) != 0) : ($urandom_range(15) == 0);
               send_block(first, rnd64(), rnd64(), 1'b0, '0);
               cnt++;
            end
         end
         drain();
      end

      if (errors == 0) begin
         $display("aes_cfb128_mode_engine_unit_tb OK");
      end else begin
         $display("aes_cfb128_mode_engine_unit_tb NOT OK");
      end
      $finish;
   end
endmodule

### files.f
sv/acfb_pkg.sv
sv/acfb_key_expand.sv
sv/aes_cfb128_mode_engine_unit.sv
dv/aes_cfb128_mode_engine_unit_tb.sv
